// ----- rtl/core/ipab_pkg.sv -----
// Shared types and constants for the any-base integer parser.
// No dependencies; imported by ipab_alpha, ipab_parse and integer_parse_any_base.
package ipab_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH = 2'd2;

	localparam int CFG_DATA_W  = 64;
	localparam int BASE_LEN_W  = 5;
	localparam int DIGIT_W     = 4;
	localparam int VALUE_W     = 32;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_DEL   = 8'd127;

	// Parse phase, one-hot
	typedef enum logic [3:0] {
		PH_SPACE = 4'b0001,
		PH_SIGN  = 4'b0010,
		PH_DIGIT = 4'b0100,
		PH_REST  = 4'b1000
	} phase_t;

	// Alphabet check and digit lookup for the current character
	typedef struct packed {
		logic               ok;
		logic               hit;
		logic [DIGIT_W-1:0] digit;
	} alpha_info_t;

endpackage

// ----- rtl/core/integer_parse_any_base.sv -----
// Top level of the any-base integer parser: config registers, input stage, result register.
// Depends on ipab_pkg, ipab_alpha and ipab_parse.
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+------------------------------
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write per word
//  in      | in_valid, in_ready, char_in               | one string byte per word
//  out     | out_valid, out_ready, value, alphabet_ok  | one result word per NUL byte
//
// One byte per cycle sustained, except while a NUL waits on an untaken result. A byte
// sits in the input stage, where the alphabet compare and the 32x5 multiply-add update
// the parse state; a NUL then loads the result register, which drives the outputs.
// Reset clears the config registers, the parse state and both valid flags.
// A NUL byte stalls in the input stage only while an untaken result is held;
// other bytes never stall. cfg_ready is always high.
module integer_parse_any_base #(
	parameter int MAX_DIGITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ipab_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipab_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      char_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [ipab_pkg::VALUE_W-1:0] value,
	output logic                            alphabet_ok
);
	import ipab_pkg::*;

	logic [CFG_DATA_W-1:0] digits_low_q;
	logic [CFG_DATA_W-1:0] digits_high_q;
	logic [BASE_LEN_W-1:0] base_length_q;
	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  out_valid_q;
	logic [VALUE_W-1:0]    value_q;
	logic                  ok_q;
	logic                  s1_is_nul;
	logic                  s1_go;
	logic                  out_free;
	alpha_info_t           info;
	logic [VALUE_W-1:0]    res_value;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_low_q  <= '0;
			digits_high_q <= '0;
			base_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DIGITS_LOW:  digits_low_q  <= cfg_data;
				CFG_DIGITS_HIGH: digits_high_q <= cfg_data;
				CFG_BASE_LENGTH: base_length_q <= cfg_data[BASE_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage handshake
	assign s1_is_nul = char_s1 == CH_NUL;
	assign out_free  = !out_valid_q || out_ready;
	assign s1_go     = valid_s1 && (!s1_is_nul || out_free);
	assign in_ready  = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
	end

	ipab_alpha #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_alpha (
		.digits_low (digits_low_q),
		.digits_high(digits_high_q),
		.base_length(base_length_q),
		.char_cur   (char_s1),
		.info       (info)
	);

	ipab_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s1_go),
		.char_cur   (char_s1),
		.base_length(base_length_q),
		.info       (info),
		.res_value  (res_value)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_is_nul) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_is_nul) begin
			value_q <= res_value;
			ok_q    <= info.ok;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign alphabet_ok = ok_q;

	// A bad alphabet always reports zero
	a_bad_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ok_q || value_q == '0))
		else $error("result with bad alphabet is not zero");

	// The input stage holds only a NUL waiting on a full result register
	a_s1_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |-> (s1_is_nul && out_valid_q && !out_ready))
		else $error("input stage stalled without cause");

	// An accepted word lands in the input stage
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted word lost before input stage");

endmodule

// ----- rtl/core/ipab_alpha.sv -----
// Alphabet checker and parallel digit lookup for the any-base integer parser.
// Depends on ipab_pkg.
module ipab_alpha #(
	parameter int MAX_DIGITS = 16
) (
	input  logic [ipab_pkg::CFG_DATA_W-1:0] digits_low,
	input  logic [ipab_pkg::CFG_DATA_W-1:0] digits_high,
	input  logic [ipab_pkg::BASE_LEN_W-1:0] base_length,
	input  logic [7:0]                      char_cur,
	output ipab_pkg::alpha_info_t           info
);
	import ipab_pkg::*;

	logic [7:0]            chr [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] in_use;
	logic [MAX_DIGITS-1:0] bad_char;
	logic [MAX_DIGITS-1:0] dup;
	logic [MAX_DIGITS-1:0] match;
	logic [MAX_DIGITS-1:0] low_one;
	logic                  len_ok;
	logic                  len_fit;
	logic [DIGIT_W-1:0]    digit_enc;

	// Alphabet characters and which lanes are in use
	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_lane
		if (i < 8) begin : g_lo
			assign chr[i] = digits_low[8*i +: 8];
		end else begin : g_hi
			assign chr[i] = digits_high[8*(i-8) +: 8];
		end
		assign in_use[i]   = base_length > BASE_LEN_W'(i);
		assign bad_char[i] = in_use[i] && (chr[i] <= CH_SPACE || chr[i] >= CH_DEL ||
			chr[i] == CH_PLUS || chr[i] == CH_MINUS);
		// lookup runs on any length that fits the lanes, even a bad alphabet
		assign match[i]    = len_fit && in_use[i] && chr[i] == char_cur;
	end

	assign len_fit = base_length <= BASE_LEN_W'(MAX_DIGITS);
	assign len_ok  = base_length >= BASE_LEN_W'(2) && len_fit;

	// Duplicate check: lane j repeats some earlier lane
	always_comb begin
		dup = '0;
		for (int j = 1; j < MAX_DIGITS; j++) begin
			for (int i = 0; i < j; i++) begin
				if (in_use[j] && chr[i] == chr[j]) begin
					dup[j] = 1'b1;
				end
			end
		end
	end

	// Lowest matching lane gives the digit value
	assign low_one = match & (~match + MAX_DIGITS'(1));

	always_comb begin
		digit_enc = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (low_one[i]) begin
				digit_enc = digit_enc | DIGIT_W'(i);
			end
		end
	end

	assign info.ok    = len_ok && !(|bad_char) && !(|dup);
	assign info.hit   = |match;
	assign info.digit = digit_enc;

endmodule

// ----- rtl/core/ipab_parse.sv -----
// Parse state (phase, sign, accumulator) and its one-step update.
// Depends on ipab_pkg; digit lookup comes from ipab_alpha.
module ipab_parse (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [7:0]                      char_cur,
	input  logic [ipab_pkg::BASE_LEN_W-1:0] base_length,
	input  ipab_pkg::alpha_info_t           info,
	output logic [ipab_pkg::VALUE_W-1:0]    res_value
);
	import ipab_pkg::*;

	phase_t              phase_q, phase_d;
	logic                neg_q, neg_d;
	logic [VALUE_W-1:0]  acc_q, acc_d;
	logic [VALUE_W-1:0]  acc_mac;
	logic                is_ws;
	logic                at_sign;
	logic                at_digit;

	// Only the low 32 bits of the wrapped accumulator reach the output
	assign acc_mac = acc_q * VALUE_W'(base_length) + VALUE_W'(info.digit);

	assign is_ws    = char_cur == CH_SPACE || (char_cur >= CH_TAB && char_cur <= CH_CR);
	assign at_sign  = (phase_q == PH_SPACE && !is_ws) || phase_q == PH_SIGN;
	assign at_digit = (at_sign && char_cur != CH_PLUS && char_cur != CH_MINUS) ||
		phase_q == PH_DIGIT;

	// Next parse state for one character
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		priority if (char_cur == CH_NUL) begin
			phase_d = PH_SPACE;
			neg_d   = 1'b0;
			acc_d   = '0;
		end else if (phase_q == PH_SPACE && is_ws) begin
			phase_d = PH_SPACE;
		end else if (at_sign && char_cur == CH_MINUS) begin
			phase_d = PH_SIGN;
			neg_d   = !neg_q;
		end else if (at_sign && char_cur == CH_PLUS) begin
			phase_d = PH_SIGN;
		end else if (at_digit && info.hit) begin
			phase_d = PH_DIGIT;
			acc_d   = acc_mac;
		end else begin
			phase_d = PH_REST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
		end
	end

	// Signed result, zero when the alphabet is bad
	assign res_value = !info.ok ? '0 : (neg_q ? -acc_q : acc_q);

endmodule
